[hw/rtl/hufc_pkg.sv]
// Shared types and constants for the Huffman build/encode/decode unit.
`default_nettype none
package hufc_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_DECODE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_BUILT  = 2'd0,
        KIND_CODE   = 2'd1,
        KIND_SYMBOL = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_BUILD  = 3'd1,
        OP_ENCODE = 3'd2,
        OP_DECODE = 3'd3,
        OP_REJECT = 3'd4
    } op_t;

    localparam int SYM_W    = 5;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 6;
    localparam int NWT_W    = 21;
    localparam int CODE_W   = 31;
    localparam int LEN_W    = 5;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd6;

    // classified command passed from front to back
    typedef struct packed {
        op_t                 op;
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] weight;
        logic                code_bit;
        logic [COUNT_W-1:0]  n;
    } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/hufc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hufc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/hufc_front.sv]
// Front end: accepts input transfers, classifies them and queues commands.
`default_nettype none
module hufc_front #(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,
    input  wire logic [1:0]                   s_tuser,
    input  wire logic                         s_tlast,
    input  wire logic [hufc_pkg::COUNT_W-1:0] symbol_count,
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output hufc_pkg::cmd_t                    q_cmd
);
    localparam int DEPTH = 2;

    hufc_pkg::cmd_t                          fifo_reg [DEPTH];
    logic                                    wr_ptr_reg, wr_ptr_next;
    logic                                    rd_ptr_reg, rd_ptr_next;
    logic [1:0]                              count_reg, count_next;
    logic [hufc_pkg::COUNT_W-1:0]            n_act;
    logic [hufc_pkg::SYM_W-1:0]              sym;
    hufc_pkg::mode_t                         mode;
    hufc_pkg::cmd_t                          cmd_in;
    logic                                    push, pop;

    assign sym  = s_tdata[4:0];
    assign mode = hufc_pkg::mode_t'(s_tuser);

    always_comb begin
        if (symbol_count < hufc_pkg::COUNT_W'(2)) begin
            n_act = hufc_pkg::COUNT_W'(2);
        end else if (symbol_count > hufc_pkg::COUNT_W'(MAX_SYMBOLS)) begin
            n_act = hufc_pkg::COUNT_W'(MAX_SYMBOLS);
        end else begin
            n_act = symbol_count;
        end
    end

    always_comb begin
        cmd_in.sym      = sym;
        cmd_in.weight   = s_tdata[20:5];
        cmd_in.code_bit = s_tdata[21];
        cmd_in.n        = n_act;
        case (mode)
            hufc_pkg::MODE_LOAD: begin
                if ({1'b0, sym} >= n_act) begin
                    cmd_in.op = hufc_pkg::OP_REJECT;
                end else if (s_tlast) begin
                    cmd_in.op = hufc_pkg::OP_BUILD;
                end else begin
                    cmd_in.op = hufc_pkg::OP_LOAD;
                end
            end
            hufc_pkg::MODE_ENCODE: cmd_in.op = hufc_pkg::OP_ENCODE;
            hufc_pkg::MODE_DECODE: cmd_in.op = hufc_pkg::OP_DECODE;
            default:               cmd_in.op = hufc_pkg::OP_REJECT;
        endcase
    end

    assign s_tready = (count_reg != 2'(DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(DEPTH))
        else $error("queue count above depth");
    a_full_no_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(DEPTH) && !pop) |=> (count_reg == 2'(DEPTH)))
        else $error("full queue changed without a pop");
endmodule
`default_nettype wire

[hw/rtl/hufc_back.sv]
// Back end: tree build, encode walk and decode step over the node RAMs.
`default_nettype none
module hufc_back #(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire hufc_pkg::cmd_t q_cmd,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [63:0]         m_tdata,
    output logic [1:0]          m_tuser
);
    localparam int NODES  = 2 * MAX_SYMBOLS - 1;
    localparam int NODE_W = $clog2(NODES);
    localparam logic [NODE_W-1:0] NONE = '1;
    localparam int WS_W = hufc_pkg::NWT_W + 1;
    localparam logic [WS_W-1:0] BIG = {1'b1, {hufc_pkg::NWT_W{1'b0}}};

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_INIT  = 12'b0000_0000_0010,
        ST_SCAN  = 12'b0000_0000_0100,
        ST_MW1   = 12'b0000_0000_1000,
        ST_MW2   = 12'b0000_0001_0000,
        ST_EPAR  = 12'b0000_0010_0000,
        ST_EPCHK = 12'b0000_0100_0000,
        ST_ELCHK = 12'b0000_1000_0000,
        ST_DRD   = 12'b0001_0000_0000,
        ST_DCHK  = 12'b0010_0000_0000,
        ST_DLEAF = 12'b0100_0000_0000,
        ST_EMIT  = 12'b1000_0000_0000
    } state_t;

    state_t                           state_reg, state_next;
    logic [NODE_W-1:0]                i_reg, i_next, j_reg, j_next, jd_reg, jd_next;
    logic                             ev_reg, ev_next;
    logic [WS_W-1:0]                  w1_reg, w1_next, w2_reg, w2_next;
    logic [NODE_W-1:0]                a_reg, a_next, b_reg, b_next;
    logic [hufc_pkg::COUNT_W-1:0]     n_reg, n_next, built_reg, built_next;
    logic                             ready_reg, ready_next;
    logic [NODE_W-1:0]                pos_reg, pos_next, c_reg, c_next, p_reg, p_next;
    logic                             bit_reg, bit_next;
    logic [hufc_pkg::CODE_W-1:0]      code_reg, code_next;
    logic [hufc_pkg::LEN_W-1:0]       len_reg, len_next;
    logic                             has_reg, has_next;
    hufc_pkg::kind_t                  kind_reg, kind_next;
    logic [hufc_pkg::SYM_W-1:0]       sym_reg, sym_next;
    logic [hufc_pkg::NWT_W-1:0]       tot_reg, tot_next;
    logic                             mval_reg, mval_next;
    logic [63:0]                      mdata_reg, mdata_next;
    logic [1:0]                       muser_reg, muser_next;

    logic                             wt_we, par_we, lft_we, rgt_we;
    logic [NODE_W-1:0]                wt_wa, par_wa, lft_wa, rgt_wa;
    logic [NODE_W-1:0]                par_wd, lft_wd, rgt_wd;
    logic [hufc_pkg::NWT_W-1:0]       wt_wd;
    logic [NODE_W-1:0]                wt_ra, par_ra, lft_ra, rgt_ra;
    logic [hufc_pkg::NWT_W-1:0]       wt_rd;
    logic [NODE_W-1:0]                par_rd, lft_rd, rgt_rd;

    logic [NODE_W-1:0]                root_build, root_built, dstep;
    logic [hufc_pkg::NWT_W-1:0]       sum;
    logic                             out_free;

    assign root_build = NODE_W'({n_reg, 1'b0}) - NODE_W'(2);
    assign root_built = NODE_W'({built_reg, 1'b0}) - NODE_W'(2);
    assign sum        = w1_reg[hufc_pkg::NWT_W-1:0] + w2_reg[hufc_pkg::NWT_W-1:0];
    assign dstep      = bit_reg ? rgt_rd : lft_rd;
    assign out_free   = !mval_reg || m_tready;
    assign q_ready    = (state_reg == ST_IDLE);

    hufc_ram #(.WIDTH(hufc_pkg::NWT_W), .DEPTH(NODES)) u_weight (
        .aclk(aclk), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd),
        .raddr(wt_ra), .rdata(wt_rd));
    hufc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_parent (
        .aclk(aclk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
        .raddr(par_ra), .rdata(par_rd));
    hufc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_left (
        .aclk(aclk), .we(lft_we), .waddr(lft_wa), .wdata(lft_wd),
        .raddr(lft_ra), .rdata(lft_rd));
    hufc_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_right (
        .aclk(aclk), .we(rgt_we), .waddr(rgt_wa), .wdata(rgt_wd),
        .raddr(rgt_ra), .rdata(rgt_rd));

    // read address selection
    always_comb begin
        wt_ra  = j_reg;
        par_ra = j_reg;
        lft_ra = pos_reg;
        rgt_ra = pos_reg;
        case (state_reg)
            ST_EPAR:  par_ra = c_reg;
            ST_ELCHK: par_ra = p_reg;
            ST_EPCHK: lft_ra = par_rd;
            ST_DCHK:  lft_ra = dstep;
            default:  ;
        endcase
    end

    // write port selection
    always_comb begin
        wt_we  = 1'b0;  wt_wa  = i_reg;  wt_wd  = sum;
        par_we = 1'b0;  par_wa = i_reg;  par_wd = NONE;
        lft_we = 1'b0;  lft_wa = i_reg;  lft_wd = NONE;
        rgt_we = 1'b0;  rgt_wa = i_reg;  rgt_wd = NONE;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (q_cmd.op == hufc_pkg::OP_LOAD ||
                                q_cmd.op == hufc_pkg::OP_BUILD)) begin
                    wt_we = 1'b1;
                    wt_wa = NODE_W'(q_cmd.sym);
                    wt_wd = hufc_pkg::NWT_W'(q_cmd.weight);
                end
            end
            ST_INIT: begin
                par_we = 1'b1;
                lft_we = 1'b1;
                rgt_we = 1'b1;
            end
            ST_MW1: begin
                wt_we  = 1'b1;
                lft_we = 1'b1;  lft_wd = a_reg;
                rgt_we = 1'b1;  rgt_wd = b_reg;
                par_we = 1'b1;  par_wa = a_reg;  par_wd = i_reg;
            end
            ST_MW2: begin
                par_we = 1'b1;  par_wa = b_reg;  par_wd = i_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        i_next = i_reg;  j_next = j_reg;  jd_next = jd_reg;  ev_next = ev_reg;
        w1_next = w1_reg;  w2_next = w2_reg;  a_next = a_reg;  b_next = b_reg;
        n_next = n_reg;  built_next = built_reg;  ready_next = ready_reg;
        pos_next = pos_reg;  c_next = c_reg;  p_next = p_reg;  bit_next = bit_reg;
        code_next = code_reg;  len_next = len_reg;
        has_next = has_reg;  kind_next = kind_reg;  sym_next = sym_reg;
        tot_next = tot_reg;
        mval_next = mval_reg;  mdata_next = mdata_reg;  muser_next = muser_reg;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    has_next  = 1'b0;
                    kind_next = hufc_pkg::KIND_REJECT;
                    sym_next  = '0;
                    tot_next  = '0;
                    code_next = '0;
                    len_next  = '0;
                    bit_next  = q_cmd.code_bit;
                    c_next    = NODE_W'(q_cmd.sym);
                    state_next = ST_EMIT;
                    case (q_cmd.op)
                        hufc_pkg::OP_LOAD: ready_next = 1'b0;
                        hufc_pkg::OP_BUILD: begin
                            ready_next = 1'b0;
                            n_next     = q_cmd.n;
                            i_next     = '0;
                            state_next = ST_INIT;
                        end
                        hufc_pkg::OP_ENCODE: begin
                            if (!ready_reg || {1'b0, q_cmd.sym} >= built_reg) begin
                                has_next = 1'b1;
                            end else begin
                                sym_next   = q_cmd.sym;
                                state_next = ST_EPAR;
                            end
                        end
                        hufc_pkg::OP_DECODE: begin
                            if (!ready_reg) begin
                                has_next = 1'b1;
                            end else begin
                                state_next = ST_DRD;
                            end
                        end
                        default: has_next = 1'b1;
                    endcase
                end
            end
            ST_INIT: begin
                if (i_reg == root_build) begin
                    i_next  = NODE_W'(n_reg);
                    j_next  = '0;
                    ev_next = 1'b0;
                    w1_next = BIG;  w2_next = BIG;
                    a_next  = '0;   b_next  = '0;
                    state_next = ST_SCAN;
                end else begin
                    i_next = i_reg + NODE_W'(1);
                end
            end
            ST_SCAN: begin
                // evaluate the entry read last cycle, issue the next read
                if (ev_reg && par_rd == NONE) begin
                    if ({1'b0, wt_rd} < w1_reg) begin
                        w2_next = w1_reg;  b_next = a_reg;
                        w1_next = {1'b0, wt_rd};  a_next = jd_reg;
                    end else if ({1'b0, wt_rd} < w2_reg) begin
                        w2_next = {1'b0, wt_rd};  b_next = jd_reg;
                    end
                end
                if (j_reg < i_reg) begin
                    jd_next = j_reg;
                    j_next  = j_reg + NODE_W'(1);
                    ev_next = 1'b1;
                end else begin
                    ev_next = 1'b0;
                    if (!ev_reg) begin
                        state_next = ST_MW1;
                    end
                end
            end
            ST_MW1: begin
                tot_next   = sum;
                state_next = ST_MW2;
            end
            ST_MW2: begin
                if (i_reg == root_build) begin
                    built_next = n_reg;
                    pos_next   = root_build;
                    ready_next = 1'b1;
                    has_next   = 1'b1;
                    kind_next  = hufc_pkg::KIND_BUILT;
                    state_next = ST_EMIT;
                end else begin
                    i_next  = i_reg + NODE_W'(1);
                    j_next  = '0;
                    ev_next = 1'b0;
                    w1_next = BIG;  w2_next = BIG;
                    a_next  = '0;   b_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_EPAR: state_next = ST_EPCHK;
            ST_EPCHK: begin
                if (par_rd == NONE) begin
                    has_next   = 1'b1;
                    kind_next  = hufc_pkg::KIND_CODE;
                    state_next = ST_EMIT;
                end else begin
                    p_next     = par_rd;
                    state_next = ST_ELCHK;
                end
            end
            ST_ELCHK: begin
                if (lft_rd != c_reg && len_reg < hufc_pkg::LEN_W'(31)) begin
                    code_next = code_reg | (hufc_pkg::CODE_W'(1) << len_reg);
                end
                len_next   = len_reg + hufc_pkg::LEN_W'(1);
                c_next     = p_reg;
                state_next = ST_EPCHK;
            end
            ST_DRD: state_next = ST_DCHK;
            ST_DCHK: begin
                if (dstep == NONE) begin
                    // missing child: back to the root, item rejected
                    pos_next   = root_built;
                    has_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    p_next     = dstep;
                    state_next = ST_DLEAF;
                end
            end
            ST_DLEAF: begin
                if (lft_rd == NONE) begin
                    pos_next  = root_built;
                    has_next  = 1'b1;
                    kind_next = hufc_pkg::KIND_SYMBOL;
                    sym_next  = hufc_pkg::SYM_W'(p_reg);
                end else begin
                    pos_next = p_reg;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!has_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    mval_next  = 1'b1;
                    muser_next = kind_reg;
                    mdata_next = {2'b00, tot_reg, len_reg, code_reg, sym_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            pos_reg   <= '0;
            built_reg <= '0;
            mval_reg  <= 1'b0;
            has_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            pos_reg   <= pos_next;
            built_reg <= built_next;
            mval_reg  <= mval_next;
            has_reg   <= has_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next;  j_reg <= j_next;  jd_reg <= jd_next;  ev_reg <= ev_next;
        w1_reg <= w1_next;  w2_reg <= w2_next;  a_reg <= a_next;  b_reg <= b_next;
        n_reg <= n_next;  c_reg <= c_next;  p_reg <= p_next;  bit_reg <= bit_next;
        code_reg <= code_next;  len_reg <= len_next;
        kind_reg <= kind_next;  sym_reg <= sym_next;  tot_reg <= tot_next;
        mdata_reg <= mdata_next;  muser_reg <= muser_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

    a_merge_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MW1) |-> (a_reg != b_reg && w1_reg <= w2_reg))
        else $error("merge picked the same node or unordered pair");
    a_pos_in_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (pos_reg <= root_built))
        else $error("decode position outside built tree");
    a_no_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && has_reg && !out_free) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output held");
endmodule
`default_nettype wire

[hw/rtl/huffman_tree_build_encode_decode_unit.sv]
// Top level: APB register, front classifier/queue and back executor.
// Build time is dominated by the one-entry-per-cycle scan of the node RAMs for each merge.
// Encode walks the parent/left RAMs from leaf to root; decode takes one tree step per item.
// One item is in the back end at a time; the two-entry queue and output register keep
// taking transfers while results wait.
// aresetn (synchronous) empties the queue, drops tree_ready, sets symbol_count to 6.
`default_nettype none
module huffman_tree_build_encode_decode_unit #(
    parameter int MAX_SYMBOLS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // symbol[4:0], weight[20:5], code_bit[21], zero
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    input  wire logic        s_tlast,   // last_weight
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // out_symbol[4:0], code_value[35:5],
                                        // code_length[40:36], total_weight[61:41], zero
    output logic [1:0]       m_tuser,   // kind[1:0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [hufc_pkg::COUNT_W-1:0] symbol_count_reg, symbol_count_next;
    logic                         q_valid, q_ready;
    hufc_pkg::cmd_t               q_cmd;

    // symbol_count lives at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {26'd0, symbol_count_reg} : 32'd0;

    always_comb begin
        symbol_count_next = symbol_count_reg;
        if (psel && penable && pwrite && paddr == 3'd0) begin
            symbol_count_next = pwdata[hufc_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= hufc_pkg::COUNT_RESET;
        end else begin
            symbol_count_reg <= symbol_count_next;
        end
    end

    hufc_front #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .symbol_count(symbol_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    hufc_back #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser));
endmodule
`default_nettype wire
